>>> sv/ptcp_pkg.sv
// ptcp_pkg: shared types and constants for the pan/tilt command parser and smoother
// no dependencies; used by ptcp_parser, ptcp_axis and pan_tilt_command_parser_smoother
package ptcp_pkg;

	localparam int ANGLE_W   = 8;
	localparam int GAIN_W    = 17;
	localparam int GAIN_FRAC = 16;
	localparam int CFG_IDX_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LERP_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MAX = 2'd2;

	// register reset values
	localparam logic [GAIN_W-1:0]  GAIN_RESET      = 17'd13107;
	localparam logic [ANGLE_W-1:0] ANGLE_MIN_RESET = 8'd0;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX_RESET = 8'd180;
	localparam logic [ANGLE_W-1:0] START_ANGLE     = 8'd90;

	// rounding term for the gain product (2^16 - 1)
	localparam logic [GAIN_FRAC-1:0] GAIN_ROUND = 16'hFFFF;

	// request kinds
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// characters
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// field parse phase
	typedef enum logic [1:0] {
		PH_SPACE = 2'd0,
		PH_TAKEN = 2'd1,
		PH_STOP  = 2'd2
	} phase_t;

	// new goals from a completed line
	typedef struct packed {
		logic               load;
		logic [ANGLE_W-1:0] pan;
		logic [ANGLE_W-1:0] tilt;
	} goal_upd_t;

endpackage

>>> sv/ptcp_parser.sv
// ptcp_parser: parses "X,Y" text lines into clamped pan and tilt goals
// depends on ptcp_pkg
module ptcp_parser #(
	parameter int VALUE_BITS = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       byte_en,
	input  logic [7:0]                 rx_byte,
	input  logic [ptcp_pkg::ANGLE_W-1:0] angle_min,
	input  logic [ptcp_pkg::ANGLE_W-1:0] angle_max,
	output ptcp_pkg::goal_upd_t        upd
);

	localparam int SUM_W = VALUE_BITS + 4;

	logic                  comma_q;
	ptcp_pkg::phase_t      phase_q;
	logic                  neg1_q, neg2_q;
	logic [VALUE_BITS-1:0] val1_q, val2_q;

	logic                  comma_d;
	ptcp_pkg::phase_t      phase_d;
	logic                  neg1_d, neg2_d;
	logic [VALUE_BITS-1:0] val1_d, val2_d;

	logic                  cur_neg, nxt_neg;
	logic [VALUE_BITS-1:0] cur_val, nxt_val;
	ptcp_pkg::phase_t      nxt_phase;
	logic                  is_digit, is_space;
	logic [SUM_W-1:0]      acc;

	function automatic logic [ptcp_pkg::ANGLE_W-1:0] clamp_fn(
		input logic                          neg,
		input logic [VALUE_BITS-1:0]         mag,
		input logic [ptcp_pkg::ANGLE_W-1:0]  lo,
		input logic [ptcp_pkg::ANGLE_W-1:0]  hi
	);
		logic [ptcp_pkg::ANGLE_W-1:0] r;
		if (neg && mag != '0)
			r = lo;
		else if (mag < VALUE_BITS'(lo))
			r = lo;
		else if (mag > VALUE_BITS'(hi))
			r = hi;
		else
			r = mag[ptcp_pkg::ANGLE_W-1:0];
		return r;
	endfunction

	always_comb begin
		is_digit = rx_byte >= ptcp_pkg::CH_ZERO && rx_byte <= ptcp_pkg::CH_NINE;
		is_space = rx_byte == ptcp_pkg::CH_SPACE ||
			(rx_byte >= ptcp_pkg::CH_TAB && rx_byte <= ptcp_pkg::CH_CR);
		cur_neg = comma_q ? neg2_q : neg1_q;
		cur_val = comma_q ? val2_q : val1_q;

		// val * 10 + digit, saturating
		acc = SUM_W'({cur_val, 3'b000}) + SUM_W'({cur_val, 1'b0})
			+ SUM_W'(rx_byte - ptcp_pkg::CH_ZERO);

		nxt_neg   = cur_neg;
		nxt_val   = cur_val;
		nxt_phase = phase_q;
		case (phase_q)
			ptcp_pkg::PH_SPACE: begin
				if (is_digit) begin
					nxt_val   = (acc[SUM_W-1:VALUE_BITS] != '0) ? '1 : acc[VALUE_BITS-1:0];
					nxt_phase = ptcp_pkg::PH_TAKEN;
				end else if (is_space) begin
					nxt_phase = ptcp_pkg::PH_SPACE;
				end else if (rx_byte == ptcp_pkg::CH_PLUS) begin
					nxt_phase = ptcp_pkg::PH_TAKEN;
				end else if (rx_byte == ptcp_pkg::CH_MINUS) begin
					nxt_neg   = 1'b1;
					nxt_phase = ptcp_pkg::PH_TAKEN;
				end else begin
					nxt_phase = ptcp_pkg::PH_STOP;
				end
			end
			ptcp_pkg::PH_TAKEN: begin
				if (is_digit) begin
					nxt_val = (acc[SUM_W-1:VALUE_BITS] != '0) ? '1 : acc[VALUE_BITS-1:0];
				end else begin
					nxt_phase = ptcp_pkg::PH_STOP;
				end
			end
			default: begin
				nxt_phase = ptcp_pkg::PH_STOP;
			end
		endcase

		comma_d  = comma_q;
		phase_d  = phase_q;
		neg1_d   = neg1_q;
		neg2_d   = neg2_q;
		val1_d   = val1_q;
		val2_d   = val2_q;
		upd.load = 1'b0;
		upd.pan  = clamp_fn(neg1_q, val1_q, angle_min, angle_max);
		upd.tilt = clamp_fn(neg2_q, val2_q, angle_min, angle_max);

		if (byte_en) begin
			if (rx_byte == ptcp_pkg::CH_NL) begin
				upd.load = comma_q;
				comma_d  = 1'b0;
				phase_d  = ptcp_pkg::PH_SPACE;
				neg1_d   = 1'b0;
				neg2_d   = 1'b0;
				val1_d   = '0;
				val2_d   = '0;
			end else if (!comma_q && rx_byte == ptcp_pkg::CH_COMMA) begin
				comma_d = 1'b1;
				phase_d = ptcp_pkg::PH_SPACE;
			end else if (!comma_q) begin
				phase_d = nxt_phase;
				neg1_d  = nxt_neg;
				val1_d  = nxt_val;
			end else begin
				phase_d = nxt_phase;
				neg2_d  = nxt_neg;
				val2_d  = nxt_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comma_q <= 1'b0;
			phase_q <= ptcp_pkg::PH_SPACE;
			neg1_q  <= 1'b0;
			neg2_q  <= 1'b0;
			val1_q  <= '0;
			val2_q  <= '0;
		end else begin
			comma_q <= comma_d;
			phase_q <= phase_d;
			neg1_q  <= neg1_d;
			neg2_q  <= neg2_d;
			val1_q  <= val1_d;
			val2_q  <= val2_d;
		end
	end

endmodule

>>> sv/ptcp_axis.sv
// ptcp_axis: one smoothed axis, goal register and fixed-point lerp step
// depends on ptcp_pkg
module ptcp_axis #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step_en,
	input  logic [ptcp_pkg::GAIN_W-1:0]  gain,
	input  logic                         goal_load,
	input  logic [ptcp_pkg::ANGLE_W-1:0] goal_val,
	output logic [ptcp_pkg::ANGLE_W-1:0] angle
);

	localparam int SW = ptcp_pkg::ANGLE_W + FRAC_BITS;
	localparam int PW = SW + ptcp_pkg::GAIN_W;
	localparam int TW = SW + 2;

	logic [ptcp_pkg::ANGLE_W-1:0] goal_q;
	logic [SW-1:0]                smooth_q;

	logic [SW-1:0]  tgt, delta, nxt;
	logic           up;
	logic [PW-1:0]  prod;
	logic [PW:0]    rnd;
	logic [TW-1:0]  step, sum;

	always_comb begin
		tgt   = {goal_q, {FRAC_BITS{1'b0}}};
		up    = tgt >= smooth_q;
		delta = up ? (tgt - smooth_q) : (smooth_q - tgt);
		prod  = PW'(delta) * PW'(gain);
		// round the step up so the axis lands on the goal
		rnd   = (PW + 1)'(prod) + (PW + 1)'(ptcp_pkg::GAIN_ROUND);
		step  = rnd[PW:ptcp_pkg::GAIN_FRAC];
		sum   = TW'(smooth_q) + step;
		if (up)
			nxt = (sum[TW-1:SW] != '0) ? '1 : sum[SW-1:0];
		else if (step > TW'(smooth_q))
			nxt = '0;
		else
			nxt = smooth_q - step[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q   <= ptcp_pkg::START_ANGLE;
			smooth_q <= {ptcp_pkg::START_ANGLE, {FRAC_BITS{1'b0}}};
		end else begin
			if (goal_load)
				goal_q <= goal_val;
			if (step_en)
				smooth_q <= nxt;
		end
	end

	assign angle = smooth_q[SW-1:FRAC_BITS];

endmodule

>>> sv/pan_tilt_command_parser_smoother.sv
// pan_tilt_command_parser_smoother: serial "X,Y" command parser with per-tick smoothing
// a tick word's angles are valid once it has left the input register and stepped the axis
// registers, which also hold the result; byte words produce no result
// throughput: one word per cycle; a tick stalls only while the previous result is untaken
// reset (arst_n low, asynchronous): axes at 90, goals 90, parser cleared, registers default
// depends on ptcp_pkg, ptcp_parser, ptcp_axis
module pan_tilt_command_parser_smoother #(
	parameter int FRAC_BITS  = 16,
	parameter int VALUE_BITS = 11
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic                            req_type,
	input  logic [7:0]                      rx_byte,
	// result channel
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [ptcp_pkg::ANGLE_W-1:0]    pan_angle,
	output logic [ptcp_pkg::ANGLE_W-1:0]    tilt_angle,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [ptcp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ptcp_pkg::GAIN_W-1:0]     cfg_data
);

	// configuration registers
	logic [ptcp_pkg::GAIN_W-1:0]  gain_q;
	logic [ptcp_pkg::ANGLE_W-1:0] amin_q;
	logic [ptcp_pkg::ANGLE_W-1:0] amax_q;

	// input register stage
	logic       s1_valid;
	logic       s1_tick;
	logic [7:0] s1_byte;

	// result handshake state; angle payload lives in the axis registers
	logic rsp_valid_q;

	logic s1_adv;
	logic byte_en, tick_en;
	ptcp_pkg::goal_upd_t upd;

	// the axis registers double as the result register, so a tick waits
	// until the previous result is taken (or is taken this cycle)
	assign s1_adv    = s1_valid && (!s1_tick || !rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid || s1_adv;
	assign byte_en   = s1_adv && !s1_tick;
	assign tick_en   = s1_adv && s1_tick;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= ptcp_pkg::GAIN_RESET;
			amin_q <= ptcp_pkg::ANGLE_MIN_RESET;
			amax_q <= ptcp_pkg::ANGLE_MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				ptcp_pkg::REG_LERP_GAIN: gain_q <= cfg_data;
				ptcp_pkg::REG_ANGLE_MIN: amin_q <= cfg_data[ptcp_pkg::ANGLE_W-1:0];
				ptcp_pkg::REG_ANGLE_MAX: amax_q <= cfg_data[ptcp_pkg::ANGLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register: loads whenever it is empty or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (req_ready) begin
			s1_valid <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			s1_tick <= req_type == ptcp_pkg::REQ_TICK;
			s1_byte <= rx_byte;
		end
	end

	// result valid: set by a tick step, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (tick_en) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// line parser: goals are loaded on a newline that closes a line with a comma
	ptcp_parser #(
		.VALUE_BITS(VALUE_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_en  (byte_en),
		.rx_byte  (s1_byte),
		.angle_min(amin_q),
		.angle_max(amax_q),
		.upd      (upd)
	);

	// horizontal axis
	ptcp_axis #(
		.FRAC_BITS(FRAC_BITS)
	) u_pan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (tick_en),
		.gain     (gain_q),
		.goal_load(upd.load),
		.goal_val (upd.pan),
		.angle    (pan_angle)
	);

	// vertical axis
	ptcp_axis #(
		.FRAC_BITS(FRAC_BITS)
	) u_tilt (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (tick_en),
		.gain     (gain_q),
		.goal_load(upd.load),
		.goal_val (upd.tilt),
		.angle    (tilt_angle)
	);

endmodule

>>> dv/tb_pan_tilt_command_parser_smoother.sv
// tb_pan_tilt_command_parser_smoother: self-checking bench for the serial pan/tilt parser
// drives byte and tick words against an in-bench predictor over several register settings
// depends on ptcp_pkg and pan_tilt_command_parser_smoother
module tb_pan_tilt_command_parser_smoother;
	import ptcp_pkg::*;

	localparam int FRAC          = 16;
	localparam int VALUE_BITS    = 11;
	localparam int POS_W         = ANGLE_W + FRAC;
	localparam longint unsigned POS_MAX = (64'd256 << FRAC) - 64'd1;
	localparam int unsigned MAG_MAX = (1 << VALUE_BITS) - 1;
	localparam int PHASE_WORDS   = 225;     // six random phases, about 1350 words
	localparam int LATENCY_SLACK = 4;       // settle time after the last owed pair is taken
	localparam int HOLD_CYCLES   = 60;      // long receiver hold-off to back up the block
	localparam int CYCLE_LIMIT   = 200000;

	typedef struct packed {
		logic [ANGLE_W-1:0] pan;
		logic [ANGLE_W-1:0] tilt;
	} angle_pair_t;

	// directed row: word kind, byte, whether the angles are pinned, pinned angles
	typedef struct packed {
		logic               kind;
		logic [7:0]         ch;
		logic               pinned;
		logic [ANGLE_W-1:0] pan;
		logic [ANGLE_W-1:0] tilt;
	} dir_row_t;

	// runs with gain 65536 and range 0..180, so every tick jumps straight to its goal
	localparam dir_row_t DIR_ROWS [0:24] = '{
		// at rest on the start angle, byte lane all ones on a tick
		'{REQ_TICK, 8'hFF,    1'b1, 8'd90, 8'd90},
		// " -7,9999": whitespace, negative below min, magnitude saturates above max
		'{REQ_BYTE, CH_SPACE, 1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, CH_MINUS, 1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, "7",      1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, CH_COMMA, 1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, "9",      1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, "9",      1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, "9",      1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, "9",      1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, CH_NL,    1'b0, 8'd0, 8'd0},
		'{REQ_TICK, 8'h00,    1'b1, 8'd0, 8'd180},
		// line with no comma, starting with a nul byte: ignored
		'{REQ_BYTE, 8'h00,    1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, "1",      1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, CH_NL,    1'b0, 8'd0, 8'd0},
		'{REQ_TICK, 8'h5A,    1'b1, 8'd0, 8'd180},
		// "\t+5,\r7,3": plus sign, carriage return skipped, second comma stops the field
		'{REQ_BYTE, CH_TAB,   1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, CH_PLUS,  1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, "5",      1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, CH_COMMA, 1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, CH_CR,    1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, "7",      1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, CH_COMMA, 1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, "3",      1'b0, 8'd0, 8'd0},
		'{REQ_BYTE, CH_NL,    1'b0, 8'd0, 8'd0},
		'{REQ_TICK, 8'hA5,    1'b1, 8'd5, 8'd7}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	logic                 req_type;
	logic [7:0]           rx_byte;
	logic                 rsp_valid;
	logic                 rsp_ready;
	logic [ANGLE_W-1:0]   pan_angle;
	logic [ANGLE_W-1:0]   tilt_angle;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [GAIN_W-1:0]    cfg_data;

	// predictor copy of the registers
	logic [GAIN_W-1:0]  gain_q;
	logic [ANGLE_W-1:0] min_q;
	logic [ANGLE_W-1:0] max_q;

	// predictor copy of the axes and the line parser
	logic [POS_W-1:0]      pan_pos;
	logic [POS_W-1:0]      tilt_pos;
	logic [ANGLE_W-1:0]    pan_goal;
	logic [ANGLE_W-1:0]    tilt_goal;
	logic                  got_comma;
	phase_t                fld_phase;
	logic                  neg_x;
	logic                  neg_y;
	logic [VALUE_BITS-1:0] mag_x;
	logic [VALUE_BITS-1:0] mag_y;

	angle_pair_t angles_due[$];     // angle pairs owed by accepted ticks, oldest first
	logic [7:0]  line_q[$];         // bytes of the line being built

	int  words_sent;
	int  pairs_checked;
	int  mismatch_count;
	int  settings_run;
	int  cycle_count;
	bit  gaps_on;
	bit  hold_pending;

	pan_tilt_command_parser_smoother #(
		.FRAC_BITS  (FRAC),
		.VALUE_BITS (VALUE_BITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_type   (req_type),
		.rx_byte    (rx_byte),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.pan_angle  (pan_angle),
		.tilt_angle (tilt_angle),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// one tick of the easing: step is |goal - pos| * gain rounded up, result kept in range
	function automatic logic [POS_W-1:0] ease_axis(input logic [POS_W-1:0] pos,
	                                               input logic [ANGLE_W-1:0] goal);
		longint unsigned aim, gap, stride, nxt;
		aim = 64'(goal) << FRAC;
		if (aim >= 64'(pos)) begin
			gap    = aim - 64'(pos);
			stride = (gap * gain_q + GAIN_ROUND) >> GAIN_FRAC;
			nxt    = 64'(pos) + stride;
		end else begin
			gap    = 64'(pos) - aim;
			stride = (gap * gain_q + GAIN_ROUND) >> GAIN_FRAC;
			nxt    = (stride > 64'(pos)) ? 64'd0 : 64'(pos) - stride;
		end
		if (nxt > POS_MAX)
			nxt = POS_MAX;
		return nxt[POS_W-1:0];
	endfunction

	// signed value clamped into the angle window, low bound checked first
	function automatic logic [ANGLE_W-1:0] bound_angle(input logic neg,
	                                                   input logic [VALUE_BITS-1:0] mag);
		int s;
		s = neg ? -int'(mag) : int'(mag);
		if (s < int'(min_q))
			return min_q;
		if (s > int'(max_q))
			return max_q;
		return s[ANGLE_W-1:0];
	endfunction

	function automatic void reset_line_parser();
		got_comma = 1'b0;
		fld_phase = PH_SPACE;
		neg_x     = 1'b0;
		neg_y     = 1'b0;
		mag_x     = '0;
		mag_y     = '0;
	endfunction

	// integer scan of one field: whitespace, one sign, digits, stop at anything else
	function automatic void take_field_char(input logic [7:0] c, input bit second);
		logic                  neg;
		logic [VALUE_BITS-1:0] mag;
		int unsigned           grown;
		neg = second ? neg_y : neg_x;
		mag = second ? mag_y : mag_x;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (fld_phase == PH_SPACE || fld_phase == PH_TAKEN) begin
				grown     = 32'(mag) * 10 + 32'(c - CH_ZERO);
				mag       = (grown > MAG_MAX) ? MAG_MAX[VALUE_BITS-1:0] : grown[VALUE_BITS-1:0];
				fld_phase = PH_TAKEN;
			end
		end else if (fld_phase == PH_SPACE) begin
			if (c == CH_PLUS) begin
				fld_phase = PH_TAKEN;
			end else if (c == CH_MINUS) begin
				neg       = 1'b1;
				fld_phase = PH_TAKEN;
			end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
				fld_phase = PH_STOP;
			end
		end else begin
			fld_phase = PH_STOP;
		end
		if (second) begin
			neg_y = neg;
			mag_y = mag;
		end else begin
			neg_x = neg;
			mag_x = mag;
		end
	endfunction

	// advance the predictor by one accepted word; returns 1 when the word owes a result
	function automatic bit apply_word(input logic kind, input logic [7:0] ch,
	                                  output angle_pair_t res);
		res = '0;
		if (kind == REQ_TICK) begin
			pan_pos  = ease_axis(pan_pos, pan_goal);
			tilt_pos = ease_axis(tilt_pos, tilt_goal);
			res.pan  = pan_pos[POS_W-1:FRAC];
			res.tilt = tilt_pos[POS_W-1:FRAC];
			return 1'b1;
		end
		if (ch == CH_NL) begin
			// only a line that had a comma loads new goals
			if (got_comma) begin
				pan_goal  = bound_angle(neg_x, mag_x);
				tilt_goal = bound_angle(neg_y, mag_y);
			end
			reset_line_parser();
		end else if (!got_comma) begin
			if (ch == CH_COMMA) begin
				got_comma = 1'b1;
				fld_phase = PH_SPACE;
			end else begin
				take_field_char(ch, 1'b0);
			end
		end else begin
			take_field_char(ch, 1'b1);
		end
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------- request side

	// offer one word, hold it until taken, then predict what it owes
	task automatic send_word(input logic kind, input logic [7:0] ch,
	                         input logic pinned, input angle_pair_t pinned_val);
		angle_pair_t res;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_type  <= kind;
		rx_byte   <= ch;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);
		words_sent++;
		if (apply_word(kind, ch, res))
			angles_due.push_back(pinned ? pinned_val : res);
	endtask

	// tick with a random byte lane, which the block must ignore
	task automatic send_tick();
		send_word(REQ_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	// one number field: optional whitespace, optional sign, digits, sometimes junk after
	task automatic build_field();
		int    pick;
		int    n;
		string digits;
		repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) begin
			pick = $urandom_range(0, 5);
			line_q.push_back((pick == 0) ? CH_SPACE : CH_TAB + 8'(pick - 1));
		end
		case ($urandom_range(0, 5))
			0: line_q.push_back(CH_PLUS);
			1: line_q.push_back(CH_MINUS);
			default: ;
		endcase
		pick = $urandom_range(0, 19);
		if (pick != 0) begin
			// mostly near the angle range, now and then far past saturation
			n = (pick == 1) ? $urandom_range(2000, 99999999) : $urandom_range(0, 300);
			if (pick == 2)
				line_q.push_back(CH_ZERO);
			digits = $sformatf("%0d", n);
			for (int i = 0; i < digits.len(); i++)
				line_q.push_back(digits[i]);
		end
		if ($urandom_range(0, 9) == 0)
			line_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// mostly well-formed "X,Y" lines, some without comma, some with extra fields, some noise
	task automatic send_line();
		int shape;
		line_q.delete();
		shape = $urandom_range(0, 99);
		if (shape < 88) begin
			build_field();
			if (shape < 70 || shape >= 80) begin
				line_q.push_back(CH_COMMA);
				build_field();
			end
			if (shape >= 80) begin
				line_q.push_back(CH_COMMA);
				build_field();
			end
		end else begin
			repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
		end
		line_q.push_back(CH_NL);
		foreach (line_q[i]) begin
			// ticks may land in the middle of a line
			if ($urandom_range(0, 19) == 0)
				send_tick();
			send_word(REQ_BYTE, line_q[i], 1'b0, '0);
		end
		repeat ($urandom_range(0, 3)) send_tick();
	endtask

	// stop offering, wait for every owed pair, then let the pipeline settle
	task automatic drain_results();
		req_valid <= 1'b0;
		while (angles_due.size() != 0) @(posedge clk);
		repeat (LATENCY_SLACK) @(posedge clk);
	endtask

	// write all three registers back to back while the block is idle
	task automatic set_regs(input logic [GAIN_W-1:0] gain, input logic [ANGLE_W-1:0] lo,
	                        input logic [ANGLE_W-1:0] hi);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_LERP_GAIN;
		cfg_data <= gain;
		@(posedge clk);
		cfg_idx  <= REG_ANGLE_MIN;
		cfg_data <= GAIN_W'(lo);
		@(posedge clk);
		cfg_idx  <= REG_ANGLE_MAX;
		cfg_data <= GAIN_W'(hi);
		@(posedge clk);
		cfg_we   <= 1'b0;
		gain_q = gain;
		min_q  = lo;
		max_q  = hi;
		settings_run++;
	endtask

	// ---------------------------------------------------------------- result side

	function automatic void note_mismatch(input string what, input int want, input int got);
		mismatch_count++;
		$error("%s: expected %0d, got %0d", what, want, got);
	endfunction

	// take results with random stalls; one long hold-off when asked
	initial begin
		angle_pair_t want;
		rsp_ready = 1'b1;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready) begin
				if (angles_due.size() == 0) begin
					note_mismatch("unexpected word, pan_angle", -1, pan_angle);
				end else begin
					want = angles_due.pop_front();
					pairs_checked++;
					if (pan_angle !== want.pan)
						note_mismatch("pan_angle", want.pan, pan_angle);
					if (tilt_angle !== want.tilt)
						note_mismatch("tilt_angle", want.tilt, tilt_angle);
				end
			end
			if (hold_pending) begin
				// sender keeps offering meanwhile, so the block has to back up
				hold_pending = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_ready <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				rsp_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d pairs still owed", cycle_count,
		         angles_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		dir_row_t row;
		int       quota;
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req_type       = REQ_BYTE;
		rx_byte        = '0;
		cfg_we         = 1'b0;
		cfg_idx        = REG_LERP_GAIN;
		cfg_data       = '0;
		gaps_on        = 1'b1;
		hold_pending   = 1'b0;
		words_sent     = 0;
		pairs_checked  = 0;
		mismatch_count = 0;
		settings_run   = 0;

		// predictor reset state
		gain_q    = GAIN_RESET;
		min_q     = ANGLE_MIN_RESET;
		max_q     = ANGLE_MAX_RESET;
		pan_pos   = POS_W'(START_ANGLE) << FRAC;
		tilt_pos  = POS_W'(START_ANGLE) << FRAC;
		pan_goal  = START_ANGLE;
		tilt_goal = START_ANGLE;
		reset_line_parser();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: unity gain so the pinned angles follow straight from the goals
		set_regs(17'd65536, 8'd0, 8'd180);
		foreach (DIR_ROWS[i]) begin
			row = DIR_ROWS[i];
			send_word(row.kind, row.ch, row.pinned, '{row.pan, row.tilt});
		end
		drain_results();

		// random part, one register setting per phase
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_regs(GAIN_RESET, ANGLE_MIN_RESET, ANGLE_MAX_RESET);
				// zero gain: axes frozen, window at its full extent
				1: set_regs(17'd0, 8'd0, 8'd255);
				// window inverted, plus the long receiver hold-off
				2: begin
					set_regs(17'd65536, 8'd255, 8'd0);
					hold_pending = 1'b1;
				end
				// gain near two: overshoot, pinned at both ends of the axis
				3: set_regs(17'h1FFFF, 8'd0, 8'd255);
				4: set_regs(GAIN_W'($urandom_range(1, 65535)), 8'($urandom_range(0, 255)),
				            8'($urandom_range(0, 255)));
				// last stretch runs without any idling
				default: begin
					gaps_on = 1'b0;
					set_regs(17'd65535, 8'd10, 8'd250);
				end
			endcase
			quota = words_sent + PHASE_WORDS;
			while (words_sent < quota)
				send_line();
			drain_results();
		end

		$display("sent %0d words and checked %0d angle pairs over %0d register settings,",
		         words_sent, pairs_checked, settings_run);
		$display("including an inverted window, zero gain and gain past unity");
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
